// ===== rtl/ble_pkg.sv =====
package ble_pkg;

  localparam int CAP_DEF = 64;
  localparam int DATA_W  = 8;
  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int ST_W    = 3;
  localparam int FIDX_W  = 6;
  localparam int CNTO_W  = 7;
  localparam int GRP     = 8;
  localparam int GRP_W   = 3;

  localparam logic signed [POS_W-1:0] POS_LAST = -7'sd1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_RMFIRST = 3'd1,
    OP_RMLAST  = 3'd2,
    OP_RMAT    = 3'd3,
    OP_FIND    = 3'd4,
    OP_RMVAL   = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_RANGE    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic pick;
  } cell_cmd_t;

endpackage

// ===== rtl/ble_cell.sv =====
module ble_cell
  import ble_pkg::*;
#(
  parameter int CAPACITY = CAP_DEF,
  parameter int CELL_IDX = 0,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  tgt,
  input  logic [CNT_W-1:0]  cnt,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [DATA_W-1:0] nbr_data,
  output logic [DATA_W-1:0] data_o,
  output logic              match_o,
  output logic [DATA_W-1:0] pick_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

  logic [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (cmd.load && (tgt == MY_IDX)) begin
      data_r <= wr_data;
    end else if (cmd.shift && (MY_IDX >= tgt)) begin
      data_r <= nbr_data;
    end
  end

  assign data_o  = data_r;
  assign match_o = (MY_CNT < cnt) && (data_r == wr_data);
  assign pick_o  = (cmd.pick && (tgt == MY_IDX)) ? data_r : '0;

endmodule

// ===== rtl/byte_list_engine_core.sv =====
// flow: append and the removals by place pass through EXEC, TAIL1 and TAIL2 before out_valid;
//   find and remove-value first pass MATCH and a SCAN walk over groups of 8 cells (1 to NGRP) before EXEC
// throughput: one word at a time; in_ready returns in the cycle the result is registered,
//   so a new word is taken only once the group walk and tail fetch of the last one are done;
//   a result still held on out_ready stalls the tail fetch until it is taken
// reset: entry count and control cleared at once; cell contents stay undefined, no clear pass
module byte_list_engine_core
  import ble_pkg::*;
#(
  parameter int CAPACITY = CAP_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic [DATA_W-1:0]       in_value,
  input  logic signed [POS_W-1:0] in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic [FIDX_W-1:0]       out_found_index,
  output logic [CNTO_W-1:0]       out_entry_count,
  output logic [DATA_W-1:0]       out_first_byte,
  output logic [DATA_W-1:0]       out_last_byte
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
  localparam int PAD   = NGRP * GRP;
  localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int CW    = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MATCH = 6'b000010,
    S_SCAN  = 6'b000100,
    S_EXEC  = 6'b001000,
    S_TAIL1 = 6'b010000,
    S_TAIL2 = 6'b100000
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  op_t                     op_r;
  logic [DATA_W-1:0]       val_r;
  logic signed [POS_W-1:0] pos_r;
  logic [PAD-1:0]          match_r;
  logic [GW-1:0]           grp_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        hit_idx_r;
  status_t                 status_r;
  status_t                 status_nxt;
  logic [IDX_W-1:0]        res_idx_r;
  logic [IDX_W-1:0]        res_idx_nxt;
  logic [DATA_W-1:0]       grp_or_r [NGRP];
  logic [DATA_W-1:0]       grp_or_nxt [NGRP];
  logic                    out_valid_r;
  logic [ST_W-1:0]         out_status_r;
  logic [FIDX_W-1:0]       out_found_r;
  logic [CNTO_W-1:0]       out_count_r;
  logic [DATA_W-1:0]       out_first_r;
  logic [DATA_W-1:0]       out_last_r;

  cell_cmd_t               cmd;
  logic [IDX_W-1:0]        tgt;
  logic [DATA_W-1:0]       cell_data [CAPACITY];
  logic [DATA_W-1:0]       pick_data [PAD];
  logic [PAD-1:0]          match_vec;
  logic                    full;
  logic                    empty;
  logic [CNT_W-1:0]        cnt_dec;
  logic [CW-1:0]           pos_u;
  logic [CW-1:0]           cnt_u;
  logic                    pe_hit;
  logic [GRP_W-1:0]        pe_idx;
  logic [DATA_W-1:0]       tail_or;
  logic [31:0]             res_idx_ext;
  logic [31:0]             cnt_ext;
  logic                    out_free;

  // cell chain, head at cell 0
  for (genvar i = 0; i < PAD; i++) begin : g_cell
    if (i < CAPACITY) begin : g_real
      logic [DATA_W-1:0] nbr;
      if (i == CAPACITY - 1) begin : g_end
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_data[i+1];
      end
      ble_cell #(
        .CAPACITY (CAPACITY),
        .CELL_IDX (i)
      ) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .tgt      (tgt),
        .cnt      (cnt_r),
        .wr_data  (val_r),
        .nbr_data (nbr),
        .data_o   (cell_data[i]),
        .match_o  (match_vec[i]),
        .pick_o   (pick_data[i])
      );
    end else begin : g_pad
      assign match_vec[i] = 1'b0;
      assign pick_data[i] = '0;
    end
  end

  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign empty   = (cnt_r == '0);
  assign cnt_dec = CNT_W'(cnt_r - 1'b1);
  assign pos_u   = CW'(pos_r[POS_W-2:0]);
  assign cnt_u   = CW'(cnt_r);

  always_comb begin
    cmd         = '0;
    tgt         = '0;
    cnt_nxt     = cnt_r;
    status_nxt  = ST_OK;
    res_idx_nxt = '0;
    if (state_r == S_EXEC) begin
      case (op_r)
        OP_APPEND: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.load = 1'b1;
            tgt      = cnt_r[IDX_W-1:0];
            cnt_nxt  = CNT_W'(cnt_r + 1'b1);
          end
        end
        OP_RMFIRST: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.shift = 1'b1;
            cnt_nxt   = cnt_dec;
          end
        end
        OP_RMLAST: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cnt_nxt = cnt_dec;
          end
        end
        OP_RMAT: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (pos_r == POS_LAST) begin
            cnt_nxt = cnt_dec;
          end else if (pos_r[POS_W-1] || (pos_u >= cnt_u)) begin
            status_nxt = ST_RANGE;
          end else begin
            cmd.shift = 1'b1;
            tgt       = IDX_W'(pos_r[POS_W-2:0]);
            cnt_nxt   = cnt_dec;
          end
        end
        OP_FIND: begin
          if (hit_r) begin
            res_idx_nxt = hit_idx_r;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        OP_RMVAL: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else if (hit_r) begin
            cmd.shift = 1'b1;
            tgt       = hit_idx_r;
            cnt_nxt   = cnt_dec;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == S_TAIL1) begin
      cmd.pick = 1'b1;
      tgt      = cnt_dec[IDX_W-1:0];
    end
  end

  // first match inside the low group of the walk
  always_comb begin
    pe_hit = |match_r[GRP-1:0];
    pe_idx = '0;
    for (int k = GRP - 1; k >= 0; k--) begin
      if (match_r[k]) begin
        pe_idx = GRP_W'(k);
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_or_nxt[g] = grp_or_nxt[g] | pick_data[g*GRP+k];
      end
    end
  end

  always_comb begin
    tail_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      tail_or = tail_or | grp_or_r[g];
    end
  end

  assign out_free    = !out_valid_r || out_ready;
  assign res_idx_ext = 32'(res_idx_r);
  assign cnt_ext     = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_TAIL2) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if ((in_op == OP_FIND) || (in_op == OP_RMVAL)) begin
              state_r <= S_MATCH;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_MATCH: state_r <= S_SCAN;
        S_SCAN: begin
          if (pe_hit || (grp_r == GW'(NGRP - 1))) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          cnt_r   <= cnt_nxt;
          state_r <= S_TAIL1;
        end
        S_TAIL1: state_r <= S_TAIL2;
        S_TAIL2: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      op_r  <= op_t'(in_op);
      val_r <= in_value;
      pos_r <= in_position;
    end
    if (state_r == S_MATCH) begin
      match_r <= match_vec;
      grp_r   <= '0;
    end
    if (state_r == S_SCAN) begin
      hit_r     <= pe_hit;
      hit_idx_r <= IDX_W'({grp_r, pe_idx});
      match_r   <= match_r >> GRP;
      grp_r     <= GW'(grp_r + 1'b1);
    end
    if (state_r == S_EXEC) begin
      status_r  <= status_nxt;
      res_idx_r <= res_idx_nxt;
    end
    if (state_r == S_TAIL1) begin
      grp_or_r <= grp_or_nxt;
    end
    if ((state_r == S_TAIL2) && out_free) begin
      out_status_r <= status_r;
      out_found_r  <= res_idx_ext[FIDX_W-1:0];
      out_count_r  <= cnt_ext[CNTO_W-1:0];
      out_first_r  <= empty ? '0 : cell_data[0];
      out_last_r   <= empty ? '0 : tail_or;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_entry_count = out_count_r;
  assign out_first_byte  = out_first_r;
  assign out_last_byte   = out_last_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_TAIL2))
    else $error("result raised outside tail fetch");

  a_cnt_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> $past(state_r == S_EXEC))
    else $error("count changed outside execute");
`endif

endmodule
